// File: hw/rtl/csi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csi_pkg: shared types and constants of the chunk spatial index
// Entry layout, item and result words, controller command/status bundles.
// ----------------------------------------------------------------------------
package csi_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int CHUNK_W         = 63;
	localparam logic [CHUNK_W-1:0] CHUNK_RESET = 63'd65536;
	localparam logic signed [31:0] CELL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] CELL_MIN = 32'sh8000_0000;
	localparam int CORNER_LAST = 5;

	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_READ   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_PARTIAL  = 2'd1,
		ST_BADSIZE  = 2'd2,
		ST_BADINDEX = 2'd3
	} status_t;

	// table read address select
	typedef enum logic [2:0] {
		RS_MID   = 3'd0,
		RS_LO    = 3'd1,
		RS_SHIFT = 3'd2,
		RS_RM    = 3'd3,
		RS_IDX   = 3'd4
	} rsel_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [63:0]        owner;
		logic [63:0]        room;
	} entry_t;

	typedef struct packed {
		mode_t              mode;
		logic [63:0]        owner_id;
		logic [63:0]        room_key;
		logic signed [63:0] box_min_x;
		logic signed [63:0] box_min_y;
		logic signed [63:0] box_min_z;
		logic signed [63:0] box_max_x;
		logic signed [63:0] box_max_y;
		logic signed [63:0] box_max_z;
		logic [9:0]         read_index;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [10:0] entry_count;
		logic [31:0] refused_count;
		logic [10:0] removed_count;
		entry_t      entry;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic    load;
		logic    div_start;
		logic    div_run;
		logic    div_save;
		logic    walk_init;
		logic    walk_next;
		logic    srch_init;
		logic    srch_upd;
		rsel_t   rsel;
		logic    refuse;
		logic    shift_init;
		logic    shift_wr;
		logic    ins_wr;
		logic    rm_init;
		logic    rm_step;
		logic    rm_fin;
		logic    clr;
		logic    rd_capture;
		logic    out_load;
		status_t out_status;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_last;
		logic corner_last;
		logic chunk_zero;
		logic lo_lt_hi;
		logic key_eq;
		logic lo_lt_held;
		logic full;
		logic shift_more;
		logic walk_last;
		logic rm_more;
		logic owner_zero;
		logic idx_ok;
		logic out_free;
	} stat_t;

	// sort key: signed cells with flipped sign bits, then unsigned ids
	function automatic logic [223:0] key_vec(entry_t e);
		return {~e.x[31], e.x[30:0], ~e.y[31], e.y[30:0], ~e.z[31], e.z[30:0],
			e.owner, e.room};
	endfunction

endpackage

// File: hw/rtl/csi_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csi_item_if: input item channel
// Valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface csi_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [63:0] owner_id;
	logic [63:0] room_key;
	logic signed [63:0] box_min_x;
	logic signed [63:0] box_min_y;
	logic signed [63:0] box_min_z;
	logic signed [63:0] box_max_x;
	logic signed [63:0] box_max_y;
	logic signed [63:0] box_max_z;
	logic [9:0]  read_index;

	modport source (output valid, mode, owner_id, room_key, box_min_x, box_min_y,
		box_min_z, box_max_x, box_max_y, box_max_z, read_index, input ready);
	modport sink (input valid, mode, owner_id, room_key, box_min_x, box_min_y,
		box_min_z, box_max_x, box_max_y, box_max_z, read_index, output ready);
endinterface

// File: hw/rtl/csi_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csi_result_if: result channel
// Valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface csi_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [10:0] entry_count;
	logic [31:0] refused_count;
	logic [10:0] removed_count;
	logic signed [31:0] cell_x;
	logic signed [31:0] cell_y;
	logic signed [31:0] cell_z;
	logic [63:0] entry_owner;
	logic [63:0] entry_room;

	modport source (output valid, status, entry_count, refused_count, removed_count,
		cell_x, cell_y, cell_z, entry_owner, entry_room, input ready);
	modport sink (input valid, status, entry_count, refused_count, removed_count,
		cell_x, cell_y, cell_z, entry_owner, entry_room, output ready);
endinterface

// File: hw/rtl/csi_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csi_cfg_if: configuration write channel
// Carries the chunk size write word.
// ----------------------------------------------------------------------------
interface csi_cfg_if;
	logic        valid;
	logic        ready;
	logic [62:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// File: hw/rtl/csi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csi_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module csi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: hw/rtl/csi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csi_ctrl: sequencing state machine
// Steps the corner divides, the cell walk, binary search, entry shift,
// owner compaction and entry reads.
// ----------------------------------------------------------------------------
module csi_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  csi_pkg::mode_t  item_mode,
	output logic            in_ready,
	input  csi_pkg::stat_t  st,
	output csi_pkg::cmd_t   cmd
);
	import csi_pkg::*;

	typedef enum logic [17:0] {
		S_IDLE   = 18'h00001,
		S_DSTART = 18'h00002,
		S_DIV    = 18'h00004,
		S_DSAVE  = 18'h00008,
		S_WINIT  = 18'h00010,
		S_PROBE  = 18'h00020,
		S_SCMP   = 18'h00040,
		S_EQRD   = 18'h00080,
		S_EQCMP  = 18'h00100,
		S_SHRD   = 18'h00200,
		S_SHWR   = 18'h00400,
		S_INS    = 18'h00800,
		S_NEXT   = 18'h01000,
		S_RMRD   = 18'h02000,
		S_RMCMP  = 18'h04000,
		S_RDRD   = 18'h08000,
		S_RDCAP  = 18'h10000,
		S_DONE   = 18'h20000
	} state_t;

	state_t  state_q, state_d;
	status_t status_q, status_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		cmd      = '0;
		cmd.rsel = RS_MID;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load    = 1'b1;
					cmd.rm_init = 1'b1;
					status_d    = ST_OK;
					unique case (item_mode)
						MODE_ADD: begin
							if (st.chunk_zero) begin
								status_d = ST_BADSIZE;
								state_d  = S_DONE;
							end else begin
								state_d = S_DSTART;
							end
						end
						MODE_REMOVE: state_d = S_RMRD;
						MODE_CLEAR: begin
							cmd.clr = 1'b1;
							state_d = S_DONE;
						end
						MODE_READ: state_d = S_RDRD;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_DSTART: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				cmd.div_run = 1'b1;
				if (st.div_last) begin
					state_d = S_DSAVE;
				end
			end
			S_DSAVE: begin
				cmd.div_save = 1'b1;
				state_d      = st.corner_last ? S_WINIT : S_DSTART;
			end
			S_WINIT: begin
				cmd.walk_init = 1'b1;
				cmd.srch_init = 1'b1;
				state_d       = S_PROBE;
			end
			S_PROBE: begin
				cmd.rsel = RS_MID;
				state_d  = st.lo_lt_hi ? S_SCMP : S_EQRD;
			end
			S_SCMP: begin
				cmd.srch_upd = 1'b1;
				state_d      = S_PROBE;
			end
			S_EQRD: begin
				cmd.rsel = RS_LO;
				if (st.lo_lt_held) begin
					state_d = S_EQCMP;
				end else if (st.full) begin
					cmd.refuse = 1'b1;
					status_d   = ST_PARTIAL;
					state_d    = S_DONE;
				end else begin
					cmd.shift_init = 1'b1;
					state_d        = S_SHRD;
				end
			end
			S_EQCMP: begin
				if (st.key_eq) begin
					state_d = S_NEXT;
				end else if (st.full) begin
					cmd.refuse = 1'b1;
					status_d   = ST_PARTIAL;
					state_d    = S_DONE;
				end else begin
					cmd.shift_init = 1'b1;
					state_d        = S_SHRD;
				end
			end
			S_SHRD: begin
				cmd.rsel = RS_SHIFT;
				state_d  = st.shift_more ? S_SHWR : S_INS;
			end
			S_SHWR: begin
				cmd.shift_wr = 1'b1;
				state_d      = S_SHRD;
			end
			S_INS: begin
				cmd.ins_wr = 1'b1;
				state_d    = S_NEXT;
			end
			S_NEXT: begin
				if (st.walk_last) begin
					state_d = S_DONE;
				end else begin
					cmd.walk_next = 1'b1;
					cmd.srch_init = 1'b1;
					state_d       = S_PROBE;
				end
			end
			S_RMRD: begin
				cmd.rsel = RS_RM;
				if (st.owner_zero) begin
					state_d = S_DONE;
				end else if (st.rm_more) begin
					state_d = S_RMCMP;
				end else begin
					cmd.rm_fin = 1'b1;
					state_d    = S_DONE;
				end
			end
			S_RMCMP: begin
				cmd.rm_step = 1'b1;
				state_d     = S_RMRD;
			end
			S_RDRD: begin
				cmd.rsel = RS_IDX;
				if (st.idx_ok) begin
					state_d = S_RDCAP;
				end else begin
					status_d = ST_BADINDEX;
					state_d  = S_DONE;
				end
			end
			S_RDCAP: begin
				cmd.rd_capture = 1'b1;
				state_d        = S_DONE;
			end
			S_DONE: begin
				cmd.out_status = status_q;
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_OK;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end
endmodule

// File: hw/rtl/csi_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csi_datapath: table datapath
// Shared bit-serial divider, walk counters, search bounds, entry table RAM,
// counters and the result register.
// ----------------------------------------------------------------------------
module csi_datapath #(
	parameter int TABLE_DEPTH = csi_pkg::TABLE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  csi_pkg::item_t   item,
	input  logic             cfg_we,
	input  logic [62:0]      cfg_data,
	input  csi_pkg::cmd_t    cmd,
	output csi_pkg::stat_t   st,
	output logic             out_valid,
	input  logic             out_ready,
	output csi_pkg::result_t out_word
);
	import csi_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = $bits(entry_t);

	// control registers
	logic [CHUNK_W-1:0] chunk_q;
	logic [CW-1:0]      held_q;
	logic [31:0]        refusals_q;
	logic               out_valid_q;

	// payload registers
	item_t              it_q;
	logic [2:0]         corner_q;
	logic [5:0]         dcnt_q;
	logic [63:0]        dvd_q;
	logic [62:0]        rem_q;
	logic               neg_q;
	logic signed [31:0] cell_q [6];
	logic signed [31:0] lx_q, ly_q, lz_q, hx_q, hy_q, hz_q;
	logic signed [31:0] wx_q, wy_q, wz_q;
	logic [CW-1:0]      lo_q, hi_q, idx_q, rmr_q, rmw_q, removed_q;
	entry_t             rdent_q;
	result_t            out_q;

	// table RAM
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	entry_t        ram_wdata, ram_rdata;
	logic [EW-1:0] ram_rbits;

	csi_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rbits)
	);
	assign ram_rdata = entry_t'(ram_rbits);

	// divider operand select and one restoring step
	logic signed [63:0] corner_val;
	logic [63:0]        rem_sh;
	logic               qbit;
	always_comb begin
		unique case (corner_q)
			3'd0: corner_val = it_q.box_min_x;
			3'd1: corner_val = it_q.box_min_y;
			3'd2: corner_val = it_q.box_min_z;
			3'd3: corner_val = it_q.box_max_x;
			3'd4: corner_val = it_q.box_max_y;
			default: corner_val = it_q.box_max_z;
		endcase
		rem_sh = {rem_q, dvd_q[63]};
		qbit   = (rem_sh >= {1'b0, chunk_q});
	end

	// floor adjust and 32-bit clamp of the finished quotient
	logic [64:0]        mag;
	logic signed [31:0] cell_res;
	always_comb begin
		mag = {1'b0, dvd_q} + 65'((neg_q && (rem_q != '0)) ? 1 : 0);
		if (!neg_q) begin
			cell_res = (mag > 65'(CELL_MAX)) ? CELL_MAX : mag[31:0];
		end else begin
			cell_res = (mag > 65'd2147483648) ? CELL_MIN : 32'(-mag[31:0]);
		end
	end

	// walk key and compares
	entry_t        key;
	logic [223:0]  kv, ev;
	logic [CW-1:0] mid;
	logic          key_le;
	logic          own_match;
	always_comb begin
		key       = '{x: wx_q, y: wy_q, z: wz_q, owner: it_q.owner_id, room: it_q.room_key};
		kv        = key_vec(key);
		ev        = key_vec(ram_rdata);
		key_le    = (kv <= ev);
		mid       = lo_q + ((hi_q - lo_q) >> 1);
		own_match = (ram_rdata.owner == it_q.owner_id);
	end

	// status to controller
	always_comb begin
		st.div_last    = (dcnt_q == '0);
		st.corner_last = (corner_q == 3'(CORNER_LAST));
		st.chunk_zero  = (chunk_q == '0);
		st.lo_lt_hi    = (lo_q < hi_q);
		st.key_eq      = (kv == ev);
		st.lo_lt_held  = (lo_q < held_q);
		st.full        = (held_q >= CW'(TABLE_DEPTH));
		st.shift_more  = (idx_q > lo_q);
		st.walk_last   = (wx_q == hx_q) && (wy_q == hy_q) && (wz_q == hz_q);
		st.rm_more     = (rmr_q < held_q);
		st.owner_zero  = (it_q.owner_id == '0);
		st.idx_ok      = (32'(it_q.read_index) < 32'(held_q));
		st.out_free    = !out_valid_q || out_ready;
	end

	// RAM ports
	logic [CW-1:0] idx_m1;
	assign idx_m1 = idx_q - CW'(1);
	always_comb begin
		unique case (cmd.rsel)
			RS_MID:   ram_raddr = AW'(mid);
			RS_LO:    ram_raddr = AW'(lo_q);
			RS_SHIFT: ram_raddr = AW'(idx_m1);
			RS_RM:    ram_raddr = AW'(rmr_q);
			RS_IDX:   ram_raddr = AW'(it_q.read_index);
			default:  ram_raddr = AW'(lo_q);
		endcase
		ram_we    = 1'b0;
		ram_waddr = AW'(lo_q);
		ram_wdata = ram_rdata;
		priority if (cmd.shift_wr) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(idx_q);
		end else if (cmd.ins_wr) begin
			ram_we    = 1'b1;
			ram_wdata = key;
		end else if (cmd.rm_step && !own_match) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(rmw_q);
		end else begin
			ram_we    = 1'b0;
		end
	end

	// control registers: chunk size, count, refusals, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q     <= CHUNK_RESET;
			held_q      <= '0;
			refusals_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				chunk_q <= cfg_data;
			end
			if (cmd.clr) begin
				held_q <= '0;
			end else if (cmd.ins_wr) begin
				held_q <= held_q + CW'(1);
			end else if (cmd.rm_fin) begin
				held_q <= rmw_q;
			end
			if (cmd.refuse) begin
				refusals_q <= refusals_q + 32'd1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			it_q     <= item;
			corner_q <= '0;
			rdent_q  <= '0;
		end
		// divider
		if (cmd.div_start) begin
			dvd_q  <= corner_val[63] ? 64'(-corner_val) : corner_val;
			neg_q  <= corner_val[63];
			rem_q  <= '0;
			dcnt_q <= 6'd63;
		end else if (cmd.div_run) begin
			rem_q  <= qbit ? 63'(rem_sh - {1'b0, chunk_q}) : rem_sh[62:0];
			dvd_q  <= {dvd_q[62:0], qbit};
			dcnt_q <= dcnt_q - 6'd1;
		end
		if (cmd.div_save) begin
			cell_q[corner_q] <= cell_res;
			corner_q         <= corner_q + 3'd1;
		end
		// walk range and counters
		if (cmd.walk_init) begin
			lx_q <= (cell_q[0] < cell_q[3]) ? cell_q[0] : cell_q[3];
			hx_q <= (cell_q[0] < cell_q[3]) ? cell_q[3] : cell_q[0];
			ly_q <= (cell_q[1] < cell_q[4]) ? cell_q[1] : cell_q[4];
			hy_q <= (cell_q[1] < cell_q[4]) ? cell_q[4] : cell_q[1];
			lz_q <= (cell_q[2] < cell_q[5]) ? cell_q[2] : cell_q[5];
			hz_q <= (cell_q[2] < cell_q[5]) ? cell_q[5] : cell_q[2];
			wx_q <= (cell_q[0] < cell_q[3]) ? cell_q[0] : cell_q[3];
			wy_q <= (cell_q[1] < cell_q[4]) ? cell_q[1] : cell_q[4];
			wz_q <= (cell_q[2] < cell_q[5]) ? cell_q[2] : cell_q[5];
		end else if (cmd.walk_next) begin
			if (wx_q != hx_q) begin
				wx_q <= wx_q + 32'sd1;
			end else begin
				wx_q <= lx_q;
				if (wy_q != hy_q) begin
					wy_q <= wy_q + 32'sd1;
				end else begin
					wy_q <= ly_q;
					wz_q <= wz_q + 32'sd1;
				end
			end
		end
		// binary search bounds
		if (cmd.srch_init) begin
			lo_q <= '0;
			hi_q <= held_q;
		end else if (cmd.srch_upd) begin
			if (key_le) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid + CW'(1);
			end
		end
		// entry shift
		if (cmd.shift_init) begin
			idx_q <= held_q;
		end else if (cmd.shift_wr) begin
			idx_q <= idx_m1;
		end
		// owner compaction
		if (cmd.rm_init) begin
			rmr_q     <= '0;
			rmw_q     <= '0;
			removed_q <= '0;
		end else if (cmd.rm_step) begin
			rmr_q <= rmr_q + CW'(1);
			if (own_match) begin
				removed_q <= removed_q + CW'(1);
			end else begin
				rmw_q <= rmw_q + CW'(1);
			end
		end
		if (cmd.rd_capture) begin
			rdent_q <= ram_rdata;
		end
		// result word
		if (cmd.out_load) begin
			out_q.status        <= cmd.out_status;
			out_q.entry_count   <= 11'(held_q);
			out_q.refused_count <= refusals_q;
			out_q.removed_count <= 11'(removed_q);
			out_q.entry         <= rdent_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;
endmodule

// File: hw/rtl/chunk_spatial_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_spatial_index: sorted grid-cell table for room lookup
// Add room (cell walk with sorted insert), remove owner, clear, read entry.
// ----------------------------------------------------------------------------
// Add: the six corner divides on the shared 1 bit/cycle divider, then per cell a
//   binary search of the sorted table plus a RAM read and a RAM write per entry
//   shifted. Remove: a read and a compare step per held entry. Clear: count reset.
// Read: RAM read, then capture. One item at a time; next item taken while
//   the result waits in its register. Reset empties the table (count 0), zeroes
//   refusals, sets chunk size 65536; no RAM clearing pass.
// ----------------------------------------------------------------------------
module chunk_spatial_index #(
	parameter int TABLE_DEPTH = csi_pkg::TABLE_DEPTH_DEF
) (
	input logic           clk,
	input logic           arst_n,
	csi_item_if.sink      item,
	csi_result_if.source  result,
	csi_cfg_if.sink       cfg
);
	import csi_pkg::*;

	item_t   item_word;
	cmd_t    cmd;
	stat_t   st;
	result_t out_word;
	logic    in_ready;

	assign item_word = '{
		mode:       mode_t'(item.mode),
		owner_id:   item.owner_id,
		room_key:   item.room_key,
		box_min_x:  item.box_min_x,
		box_min_y:  item.box_min_y,
		box_min_z:  item.box_min_z,
		box_max_x:  item.box_max_x,
		box_max_y:  item.box_max_y,
		box_max_z:  item.box_max_z,
		read_index: item.read_index
	};

	assign item.ready = in_ready;
	assign cfg.ready  = 1'b1;

	csi_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_mode  (mode_t'(item.mode)),
		.in_ready   (in_ready),
		.st         (st),
		.cmd        (cmd)
	);

	csi_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_word),
		.cfg_we    (cfg.valid),
		.cfg_data  (cfg.data),
		.cmd       (cmd),
		.st        (st),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_word  (out_word)
	);

	assign result.status        = out_word.status;
	assign result.entry_count   = out_word.entry_count;
	assign result.refused_count = out_word.refused_count;
	assign result.removed_count = out_word.removed_count;
	assign result.cell_x        = out_word.entry.x;
	assign result.cell_y        = out_word.entry.y;
	assign result.cell_z        = out_word.entry.z;
	assign result.entry_owner   = out_word.entry.owner;
	assign result.entry_room    = out_word.entry.room;
endmodule
